@@ hw/rtl/spq_pkg.sv @@
// Shared types and constants for the sorted priority queue.
package spq_pkg;

  localparam int unsigned CAPACITY_DEF = 128;
  localparam int unsigned DEV_W        = 8;
  localparam int unsigned PRIO_W       = 8;
  localparam int unsigned TAG_W        = 16;
  localparam int unsigned OCC_W        = 8;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_REPRIO = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic [DEV_W-1:0]  dev;
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  typedef struct packed {
    action_e           action;
    logic [DEV_W-1:0]  device_id;
    logic [PRIO_W-1:0] priority_req;
    logic [TAG_W-1:0]  request_tag;
  } in_word_t;

  typedef struct packed {
    status_e           status;
    logic [DEV_W-1:0]  out_device_id;
    logic [PRIO_W-1:0] out_priority;
    logic [TAG_W-1:0]  out_tag;
    logic [OCC_W-1:0]  occupancy;
  } out_word_t;

  // what every cell does in a cycle
  typedef enum logic [1:0] {
    CM_HOLD   = 2'd0,
    CM_INSERT = 2'd1,
    CM_PULL   = 2'd2
  } cell_mode_e;

  // broadcast to the whole row; item.dev doubles as the search key
  typedef struct packed {
    cell_mode_e mode;
    entry_t     item;
  } cell_ctrl_t;

endpackage

@@ hw/rtl/sorted_priority_queue_reprioritize.sv @@
// Top level of the sorted priority queue with reprioritize by device id.
//
// Bounded priority queue held in a row of CAPACITY cells, kept sorted with the
// highest priority in cell 0; equal priorities keep arrival order. One input
// word is taken at a time and gives exactly one result word. For insert,
// remove head and clear the word is first captured, then every cell compares
// against the broadcast entry and keeps, takes the new entry or takes its
// neighbor's. For reprioritize the row flags every match, a log-step prefix
// scan picks the first match and its tag, the row closes the gap behind it,
// and the entry is inserted again with its new priority. The result sits in
// an output register, so a stalled result does not hold up acceptance of the
// next word; the queue moves on to its update once that register is free.
// Occupancy is reported in 8 bits (modulo 256). Stored entries carry no reset;
// only cells below the count are ever read.
module sorted_priority_queue_reprioritize import spq_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_TAKE  = 5'b01000,
    S_PLACE = 5'b10000
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  in_word_t        req_q;
  out_word_t       out_q, res;
  logic            out_valid_q;
  logic            accept, out_free, emit;

  // cell row
  cell_ctrl_t                     ctrl;
  entry_t                         ent     [CAPACITY];
  logic       [CAPACITY-1:0]      stay;
  logic       [CAPACITY-1:0]      match;
  logic       [CAPACITY-1:0]      pull;
  logic       [CAPACITY-1:0][TAG_W-1:0] tags;

  // scan unit
  logic                scan_load, scan_step, scan_last, scan_found;
  logic [CAPACITY-1:0] scan_hit;
  logic [TAG_W-1:0]    scan_tag;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    emit          = 1'b0;
    scan_load     = 1'b0;
    scan_step     = 1'b0;
    res           = '0;
    res.status    = ST_OK;
    ctrl.mode     = CM_HOLD;
    ctrl.item.dev = req_q.device_id;
    ctrl.item.prio = req_q.priority_req;
    ctrl.item.tag = req_q.request_tag;
    pull          = '1;   // remove head: every cell takes its right neighbor

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (req_q.action == ACT_REPRIO) begin
          // freeze the match flags of the row into the scan
          scan_load = 1'b1;
          state_d   = S_SCAN;
        end else if (out_free) begin
          emit    = 1'b1;
          state_d = S_IDLE;
          case (req_q.action)
            ACT_INSERT: begin
              if (cnt_q == CntW'(CAPACITY)) begin
                res.status = ST_FULL;
              end else begin
                ctrl.mode = CM_INSERT;
                cnt_d     = cnt_q + CntW'(1);
              end
            end
            ACT_REMOVE: begin
              if (cnt_q == '0) begin
                res.status = ST_EMPTY;
              end else begin
                ctrl.mode         = CM_PULL;
                cnt_d             = cnt_q - CntW'(1);
                res.out_device_id = ent[0].dev;
                res.out_priority  = ent[0].prio;
                res.out_tag       = ent[0].tag;
              end
            end
            default: begin
              cnt_d = '0;
            end
          endcase
        end
      end
      S_SCAN: begin
        scan_step = 1'b1;
        if (scan_last) begin
          state_d = S_TAKE;
        end
      end
      S_TAKE: begin
        if (scan_found) begin
          // cells at and after the first match close the gap
          ctrl.mode = CM_PULL;
          pull      = scan_hit;
          cnt_d     = cnt_q - CntW'(1);
          state_d   = S_PLACE;
        end else if (out_free) begin
          res.status = ST_NOT_FOUND;
          emit       = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_PLACE: begin
        ctrl.item.tag = scan_tag;
        if (out_free) begin
          ctrl.mode = CM_INSERT;
          cnt_d     = cnt_q + CntW'(1);
          emit      = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    res.occupancy = OCC_W'(cnt_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_word_i;
    end
    if (emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // ---------------------------------------------------------------------------
  // Row of cells; cell 0 is the head. The left edge always "stays", so cell 0
  // takes the new entry when it does not keep its own; the right edge recycles.
  // ---------------------------------------------------------------------------
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    entry_t left_ent, right_ent;
    logic   left_stay;

    if (g == 0) begin : g_head
      assign left_ent  = ent[g];
      assign left_stay = 1'b1;
    end else begin : g_body
      assign left_ent  = ent[g-1];
      assign left_stay = stay[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign right_ent = ent[g];
    end else begin : g_inner
      assign right_ent = ent[g+1];
    end

    spq_cell #(
      .IDX  (g),
      .CNTW (CntW)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .cnt_i       (cnt_q),
      .left_i      (left_ent),
      .left_stay_i (left_stay),
      .right_i     (right_ent),
      .pull_i      (pull[g]),
      .ent_o       (ent[g]),
      .stay_o      (stay[g]),
      .match_o     (match[g])
    );

    assign tags[g] = ent[g].tag;
  end

  spq_scan #(
    .CAPACITY (CAPACITY)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (scan_load),
    .step_i  (scan_step),
    .match_i (match),
    .tag_i   (tags),
    .last_o  (scan_last),
    .hit_o   (scan_hit),
    .found_o (scan_found),
    .tag_o   (scan_tag)
  );

endmodule

@@ hw/rtl/spq_cell.sv @@
// One slot of the sorted row: holds an entry, compares, shifts with its neighbors.
module spq_cell import spq_pkg::*; #(
  parameter int unsigned IDX  = 0,
  parameter int unsigned CNTW = 8
) (
  input  logic            clk_i,
  input  cell_ctrl_t      ctrl_i,
  input  logic [CNTW-1:0] cnt_i,
  input  entry_t          left_i,
  input  logic            left_stay_i,
  input  entry_t          right_i,
  input  logic            pull_i,
  output entry_t          ent_o,
  output logic            stay_o,
  output logic            match_o
);

  entry_t ent_q, ent_d;
  logic   occ;

  assign occ     = CNTW'(IDX) < cnt_i;
  assign stay_o  = occ && (ent_q.prio >= ctrl_i.item.prio);
  assign match_o = occ && (ent_q.dev == ctrl_i.item.dev);
  assign ent_o   = ent_q;

  always_comb begin
    ent_d = ent_q;
    case (ctrl_i.mode)
      CM_INSERT: begin
        if (!stay_o) begin
          ent_d = left_stay_i ? ctrl_i.item : left_i;
        end
      end
      CM_PULL: begin
        if (pull_i) begin
          ent_d = right_i;
        end
      end
      default: ent_d = ent_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

@@ hw/rtl/spq_scan.sv @@
// Log-step prefix scan that finds the first matching slot and its tag.
module spq_scan import spq_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             load_i,
  input  logic                             step_i,
  input  logic [CAPACITY-1:0]              match_i,
  input  logic [CAPACITY-1:0][TAG_W-1:0]   tag_i,
  output logic                             last_o,
  output logic [CAPACITY-1:0]              hit_o,
  output logic                             found_o,
  output logic [TAG_W-1:0]                 tag_o
);

  localparam int unsigned Levels = $clog2(CAPACITY);
  localparam int unsigned LvlW   = (Levels > 1) ? $clog2(Levels) : 1;

  logic [CAPACITY-1:0]            f_q, f_d;
  logic [CAPACITY-1:0][TAG_W-1:0] t_q, t_d;
  logic [LvlW-1:0]                lvl_q;

  // earliest match wins: a lane takes the value d lanes below if that one is flagged
  always_comb begin
    f_d = f_q;
    t_d = t_q;
    for (int i = 0; i < CAPACITY; i++) begin
      for (int l = 0; l < Levels; l++) begin
        if (lvl_q == LvlW'(l) && i >= (1 << l)) begin
          if (f_q[i - (1 << l)]) begin
            f_d[i] = 1'b1;
            t_d[i] = t_q[i - (1 << l)];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      f_q <= match_i;
      t_q <= tag_i;
    end else if (step_i) begin
      f_q <= f_d;
      t_q <= t_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q <= '0;
    end else if (load_i) begin
      lvl_q <= '0;
    end else if (step_i) begin
      lvl_q <= lvl_q + LvlW'(1);
    end
  end

  assign last_o  = lvl_q == LvlW'(Levels - 1);
  assign hit_o   = f_q;
  assign found_o = f_q[CAPACITY-1];
  assign tag_o   = t_q[CAPACITY-1];

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the sorted priority queue with reprioritize by device id.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int unsigned DEPTH        = CAPACITY_DEF;
  localparam int unsigned RANDOM_ITEMS = 1550;
  localparam int unsigned DRAIN_CYCLES = 32;
  localparam int unsigned MAX_REPORTS  = 10;

  // random traffic shapes: climb to full, run the queue dry, or a bit of everything
  typedef enum int {
    MIX_MODE,
    FILL_MODE,
    DRAIN_MODE
  } phase_e;

  // one directed request; typed rows carry a result that is obvious by inspection
  typedef struct {
    in_word_t  word;
    bit        typed;
    out_word_t res;
  } stim_row_t;

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;

  // shadow copy of the queue, updated once per accepted request word
  entry_t      shadow_q [DEPTH];
  int unsigned shadow_count = 0;
  out_word_t   awaited_results [$];
  int unsigned fail_count = 0;
  bit          calm = 1'b0;  // high during the stretch with no idling on either side
  stim_row_t   script [$];

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  sorted_priority_queue_reprioritize #(
    .CAPACITY(DEPTH)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  // ---------------------------------------------------------------------------
  // Shadow queue
  // ---------------------------------------------------------------------------

  // sorted insert: lands behind every entry of equal or higher priority
  function automatic void shadow_place(entry_t e);
    int unsigned i;
    i = shadow_count;
    while (i > 0 && shadow_q[i-1].prio < e.prio) begin
      shadow_q[i] = shadow_q[i-1];
      i--;
    end
    shadow_q[i] = e;
    shadow_count++;
  endfunction

  // drop the entry at pos and close the gap toward the head
  function automatic void shadow_take(int unsigned pos);
    for (int unsigned j = pos; j + 1 < shadow_count; j++) begin
      shadow_q[j] = shadow_q[j+1];
    end
    shadow_count--;
  endfunction

  // result word for one request, advancing the shadow queue
  function automatic out_word_t queue_response(in_word_t w);
    out_word_t r;
    entry_t    e;
    int        pos;
    r = '0;
    r.status = ST_OK;
    case (w.action)
      ACT_INSERT: begin
        if (shadow_count < DEPTH) begin
          e.dev  = w.device_id;
          e.prio = w.priority_req;
          e.tag  = w.request_tag;
          shadow_place(e);
        end else begin
          r.status = ST_FULL;
        end
      end
      ACT_REMOVE: begin
        if (shadow_count > 0) begin
          r.out_device_id = shadow_q[0].dev;
          r.out_priority  = shadow_q[0].prio;
          r.out_tag       = shadow_q[0].tag;
          shadow_take(0);
        end else begin
          r.status = ST_EMPTY;
        end
      end
      ACT_REPRIO: begin
        // first match from the head wins
        pos = -1;
        for (int i = 0; i < int'(shadow_count); i++) begin
          if (pos < 0 && shadow_q[i].dev == w.device_id) pos = i;
        end
        if (pos >= 0) begin
          e = shadow_q[pos];
          shadow_take(pos);
          e.prio = w.priority_req;
          shadow_place(e);
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      default: begin
        shadow_count = 0;
      end
    endcase
    r.occupancy = OCC_W'(shadow_count);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic stim_row_t stim(action_e a, logic [DEV_W-1:0] dev,
                                     logic [PRIO_W-1:0] prio, logic [TAG_W-1:0] tag,
                                     bit typed, out_word_t res);
    stim_row_t s;
    s.word.action       = a;
    s.word.device_id    = dev;
    s.word.priority_req = prio;
    s.word.request_tag  = tag;
    s.typed             = typed;
    s.res               = res;
    return s;
  endfunction

  // Random request shaped by the phase. Narrow id and priority ranges make
  // duplicate ids (first match matters) and priority ties (arrival order)
  // common; reprioritize mostly targets an id that is really held.
  function automatic in_word_t pick_request(phase_e ph);
    in_word_t w;
    int       roll;
    int       ins_lim;
    int       rem_lim;
    int       rep_lim;
    case (ph)
      FILL_MODE: begin
        ins_lim = 85; rem_lim = 90; rep_lim = 100;
      end
      DRAIN_MODE: begin
        ins_lim = 15; rem_lim = 80; rep_lim = 100;
      end
      default: begin
        ins_lim = 40; rem_lim = 70; rep_lim = 97;
      end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < ins_lim)      w.action = ACT_INSERT;
    else if (roll < rem_lim) w.action = ACT_REMOVE;
    else if (roll < rep_lim) w.action = ACT_REPRIO;
    else                     w.action = ACT_CLEAR;
    if ($urandom_range(0, 99) < 40) w.device_id = DEV_W'($urandom_range(0, 15));
    else                            w.device_id = DEV_W'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < 30) w.priority_req = PRIO_W'($urandom_range(120, 123));
    else                            w.priority_req = PRIO_W'($urandom_range(0, 255));
    w.request_tag = TAG_W'($urandom_range(0, 65535));
    if (w.action == ACT_REPRIO && shadow_count > 0 && $urandom_range(0, 99) < 80) begin
      w.device_id = shadow_q[$urandom_range(0, shadow_count - 1)].dev;
    end
    return w;
  endfunction

  // Present one request word; called just after a falling edge, returns just
  // after the falling edge that follows acceptance with valid still high.
  // Random idle cycles go in front of the word, never between raise and accept.
  task automatic drive_request(in_word_t w, bit typed, out_word_t res);
    out_word_t guess;
    while (!calm && $urandom_range(0, 99) < 19) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    // accepted at this edge: run the shadow queue even for typed rows
    guess = queue_response(w);
    awaited_results.push_back(typed ? res : guess);
    @(negedge clk_i);
  endtask

  function automatic string fmt_word(out_word_t r);
    return $sformatf("st=%0d dev=%h prio=%h tag=%h occ=%0d",
                     r.status, r.out_device_id, r.out_priority, r.out_tag, r.occupancy);
  endfunction

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("[%0t] %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, compare against the oldest expectation
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 19);
  end

  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_results.size() == 0) begin
        note_failure({"result word with none expected: ", fmt_word(out_word_o)});
      end else begin
        want = awaited_results.pop_front();
        if (out_word_o.status        !== want.status        ||
            out_word_o.out_device_id !== want.out_device_id ||
            out_word_o.out_priority  !== want.out_priority  ||
            out_word_o.out_tag       !== want.out_tag       ||
            out_word_o.occupancy     !== want.occupancy) begin
          note_failure({"mismatch: exp ", fmt_word(want), " got ", fmt_word(out_word_o)});
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    phase_e      ph;
    int unsigned left;
    int unsigned n;

    // Directed script. Typed rows: results after reset, at the field
    // extremes, and the status codes. Everything else goes to the shadow queue.
    script.push_back(stim(ACT_REMOVE, 8'h00, 8'h00, 16'h0000, 1'b1,
                          out_word_t'{ST_EMPTY, 8'h00, 8'h00, 16'h0000, 8'd0}));
    script.push_back(stim(ACT_REPRIO, 8'h00, 8'h00, 16'h0000, 1'b1,
                          out_word_t'{ST_NOT_FOUND, 8'h00, 8'h00, 16'h0000, 8'd0}));
    script.push_back(stim(ACT_INSERT, 8'h00, 8'h00, 16'h0000, 1'b1,
                          out_word_t'{ST_OK, 8'h00, 8'h00, 16'h0000, 8'd1}));
    script.push_back(stim(ACT_INSERT, 8'hff, 8'hff, 16'hffff, 1'b1,
                          out_word_t'{ST_OK, 8'h00, 8'h00, 16'h0000, 8'd2}));
    script.push_back(stim(ACT_REMOVE, 8'h00, 8'h00, 16'h0000, 1'b1,
                          out_word_t'{ST_OK, 8'hff, 8'hff, 16'hffff, 8'd1}));
    script.push_back(stim(ACT_REMOVE, 8'hff, 8'hff, 16'hffff, 1'b1,
                          out_word_t'{ST_OK, 8'h00, 8'h00, 16'h0000, 8'd0}));
    script.push_back(stim(ACT_REMOVE, 8'h5a, 8'ha5, 16'h1234, 1'b1,
                          out_word_t'{ST_EMPTY, 8'h00, 8'h00, 16'h0000, 8'd0}));
    // priority ties, a duplicate id, alternating bit patterns
    script.push_back(stim(ACT_INSERT, 8'h10, 8'h80, 16'h1111, 1'b0, '0));
    script.push_back(stim(ACT_INSERT, 8'h11, 8'h80, 16'h2222, 1'b0, '0));
    script.push_back(stim(ACT_INSERT, 8'h12, 8'h81, 16'h3333, 1'b0, '0));
    script.push_back(stim(ACT_INSERT, 8'h10, 8'h7f, 16'h4444, 1'b0, '0));
    script.push_back(stim(ACT_INSERT, 8'h55, 8'haa, 16'h5555, 1'b0, '0));
    script.push_back(stim(ACT_INSERT, 8'haa, 8'h55, 16'haaaa, 1'b0, '0));
    // first dev 10 moves behind its equal-priority neighbor
    script.push_back(stim(ACT_REPRIO, 8'h10, 8'h80, 16'h0000, 1'b0, '0));
    script.push_back(stim(ACT_REPRIO, 8'h12, 8'h00, 16'h0000, 1'b0, '0));
    script.push_back(stim(ACT_REPRIO, 8'haa, 8'hff, 16'h0000, 1'b0, '0));
    script.push_back(stim(ACT_REPRIO, 8'h99, 8'h40, 16'h0000, 1'b1,
                          out_word_t'{ST_NOT_FOUND, 8'h00, 8'h00, 16'h0000, 8'd6}));
    script.push_back(stim(ACT_REMOVE, 8'h00, 8'h00, 16'h0000, 1'b0, '0));
    script.push_back(stim(ACT_REMOVE, 8'h00, 8'h00, 16'h0000, 1'b0, '0));
    script.push_back(stim(ACT_CLEAR,  8'h00, 8'h00, 16'h0000, 1'b1,
                          out_word_t'{ST_OK, 8'h00, 8'h00, 16'h0000, 8'd0}));
    script.push_back(stim(ACT_REMOVE, 8'h00, 8'h00, 16'h0000, 1'b1,
                          out_word_t'{ST_EMPTY, 8'h00, 8'h00, 16'h0000, 8'd0}));
    script.push_back(stim(ACT_CLEAR,  8'hff, 8'hff, 16'hffff, 1'b1,
                          out_word_t'{ST_OK, 8'h00, 8'h00, 16'h0000, 8'd0}));
    script.push_back(stim(ACT_INSERT, 8'h3c, 8'hc3, 16'hbeef, 1'b0, '0));
    script.push_back(stim(ACT_REMOVE, 8'h00, 8'h00, 16'h0000, 1'b0, '0));

    // single reset pulse, released on a falling edge
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (script[i]) begin
      drive_request(script[i].word, script[i].typed, script[i].res);
    end

    // Random phases. Fill phases are long enough to hit full and keep pushing
    // (dropped inserts); drain phases run dry and poke the empty queue.
    n = 0;
    while (n < RANDOM_ITEMS) begin
      ph   = phase_e'($urandom_range(0, 2));
      left = (ph == FILL_MODE) ? $urandom_range(180, 260) : $urandom_range(30, 150);
      while (left > 0 && n < RANDOM_ITEMS) begin
        calm = (n >= 500 && n < 800);
        drive_request(pick_request(ph), 1'b0, '0);
        n++;
        left--;
      end
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    // drain outstanding results, then watch for strays
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (awaited_results.size() != 0) begin
      note_failure($sformatf("%0d expected results never arrived", awaited_results.size()));
    end

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // hard ceiling far above the slowest legal run
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
